// ----- rtl/imcp_pkg.sv -----
`timescale 1ns / 1ps

package imcp_pkg;

  // Field widths of the channels.
  localparam int SPECIES_W = 7;
  localparam int PRES_W    = 32;
  localparam int AMT_W     = 32;
  localparam int POT_W     = 48;
  localparam int TEMP_W    = 32;
  localparam int IDX_OUT_W = 6;
  localparam int STATUS_W  = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 32;

  // Defaults for the top-level parameters.
  localparam int DEF_MAX_SPECIES       = 64;
  localparam int DEF_LOG_FRACTION_BITS = 16;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_STATE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_MISMATCH  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NEGATIVE  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ZERO_SUM  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_ZERO_ACT  = 3'd5;

  // Configuration register indexes and reset values.
  localparam logic [CFG_IDX_W-1:0] CFG_SPECIES_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_PRESSURE  = 1'b1;
  localparam logic [SPECIES_W-1:0] SPECIES_COUNT_RST = 7'd1;
  localparam logic [PRES_W-1:0]    REF_PRESSURE_RST  = 32'd101325;

endpackage

// ----- rtl/imcp_in_if.sv -----
`timescale 1ns / 1ps

interface imcp_in_if;
  import imcp_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic signed [AMT_W-1:0]  mole_amount;
  logic signed [POT_W-1:0]  standard_potential;
  logic [TEMP_W-1:0]        temperature;
  logic [PRES_W-1:0]        pressure;
  logic                     last_species;

  modport source (output valid, mode, mole_amount, standard_potential, temperature,
                  pressure, last_species, input ready);
  modport sink (input valid, mode, mole_amount, standard_potential, temperature,
                pressure, last_species, output ready);
endinterface

// ----- rtl/imcp_out_if.sv -----
`timescale 1ns / 1ps

interface imcp_out_if;
  import imcp_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [POT_W-1:0] potential;
  logic [IDX_OUT_W-1:0]    species_index;
  logic [STATUS_W-1:0]     status;
  logic                    last_result;

  modport source (output valid, potential, species_index, status, last_result,
                  input ready);
  modport sink (input valid, potential, species_index, status, last_result,
                output ready);
endinterface

// ----- rtl/imcp_cfg_if.sv -----
`timescale 1ns / 1ps

interface imcp_cfg_if;
  import imcp_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  wr_index;
  logic [CFG_DATA_W-1:0] wr_data;

  modport source (output valid, wr_index, wr_data, input ready);
  modport sink (input valid, wr_index, wr_data, output ready);
endinterface

// ----- rtl/ideal_mixture_chemical_potential.sv -----
`timescale 1ns / 1ps

// Ideal mixture chemical potential unit.
// A mixture enters on in_item, one species per item; the item with last_species
// set also carries mode, temperature and pressure. Non-last items are stored
// back to back and give no result. After the last item the block emits, on
// out_item, one result per species in load order, or a single error result.
// cfg_port writes species_count (index 0) or the reference pressure (index 1)
// and is always ready; write it only while the block is idle.
// Every logarithm runs on one shared 32x32 multiplier: normalization shifts one
// bit a cycle, then 32 squarings follow. A species result takes a read, a
// logarithm of the amount and two products. The last item adds one logarithm
// of the sum, two more in gas mode, and the R*T product before the first
// result.
// in_item is ready only while idle. A result waits in the output register while
// the receiver stalls and work pauses until it is taken.
// Reset (rst_n low, synchronous) clears the load counters and restores the
// configuration reset values; the species stores need no clearing.
module ideal_mixture_chemical_potential #(
  parameter int MAX_SPECIES       = imcp_pkg::DEF_MAX_SPECIES,
  parameter int LOG_FRACTION_BITS = imcp_pkg::DEF_LOG_FRACTION_BITS
) (
  input  logic           clk,
  input  logic           rst_n,
  imcp_cfg_if.sink       cfg_port,
  imcp_in_if.sink        in_item,
  imcp_out_if.source     out_item
);
  import imcp_pkg::*;

  localparam int IDX_W  = (MAX_SPECIES > 1) ? $clog2(MAX_SPECIES) : 1;
  localparam int CNT_W  = $clog2(MAX_SPECIES + 2);
  localparam int CMP_W  = (CNT_W > SPECIES_W) ? CNT_W : SPECIES_W;
  localparam int SUM_W  = AMT_W + $clog2(MAX_SPECIES + 1);
  localparam int LOG_W  = 38;
  localparam int BASE_W = LOG_W + 3;
  localparam int LN_SH  = 60 - LOG_FRACTION_BITS;
  localparam logic [63:0] R_Q24   = (64'd8314462618 << 24) / 64'd1000000000;
  localparam logic [63:0] LN2_Q28 = 64'd186065279;
  localparam logic [5:0]  K_TOP   = 6'd62;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SPECIES);
  localparam logic [63:0] TERM_MAX = 64'h0000_8000_0000_0000;
  localparam logic signed [POT_W+1:0] POT_HI = (POT_W+2)'(64'sh0000_7FFF_FFFF_FFFF);
  localparam logic signed [POT_W+1:0] POT_LO = -(POT_W+2)'(64'sh0000_8000_0000_0000);

  typedef enum logic [3:0] {
    S_IDLE, S_NORM, S_MUL, S_SQ_POST, S_RT_POST, S_READ, S_AMT, S_LN_POST,
    S_TERM_POST, S_OUT
  } state_t;

  typedef enum logic [1:0] {J_SUM, J_PRES, J_REF, J_AMT} job_t;

  // (p >> sh) saturated to 64 bits.
  function automatic logic [63:0] mul_shr(input logic [127:0] p, input int sh);
    logic [127:0] s;
    s = p >> sh;
    if (s[127:64] != 64'd0) return '1;
    return s[63:0];
  endfunction

  state_t state_r, mpost_r;
  job_t   job_r;

  logic [SPECIES_W-1:0] spc_cnt_r;
  logic [PRES_W-1:0]    ref_p_r;
  logic [CNT_W-1:0]     cnt_r, n_r;
  logic [SUM_W-1:0]     sum_r;
  logic                 neg_r, zero_r, gas_r, neg_d_r;
  logic [IDX_W-1:0]     zidx_r, idx_r;
  logic [TEMP_W-1:0]    temp_r;
  logic [PRES_W-1:0]    pres_r;
  logic [63:0]          m_r, mul_a_r, mul_b_r, pp_r, rt_r;
  logic [5:0]           k_r;
  logic [31:0]          frac_r;
  logic [4:0]           it_r;
  logic [2:0]           mcnt_r;
  logic [127:0]         acc_r;
  logic signed [BASE_W-1:0] base_r;
  logic [AMT_W-1:0]     amt_rd_r;
  logic [POT_W-1:0]     pot_rd_r;
  logic                 out_valid_r, out_last_r;
  logic signed [POT_W-1:0] out_pot_r;
  logic [IDX_OUT_W-1:0] out_idx_r;
  logic [STATUS_W-1:0]  out_st_r;

  logic [AMT_W-1:0] amt_mem [MAX_SPECIES];
  logic [POT_W-1:0] pot_mem [MAX_SPECIES];

  // Load bookkeeping for the item on the input channel.
  logic                in_acc, amt_neg, store_ok, zero_hit, in_gas;
  logic [CNT_W-1:0]    cnt_nxt;
  logic [SUM_W-1:0]    sum_nxt;
  logic                neg_nxt, zero_nxt;
  logic [IDX_W-1:0]    zidx_nxt;
  logic [STATUS_W-1:0] st_w;

  assign in_item.ready = (state_r == S_IDLE);
  assign in_acc   = in_item.valid && in_item.ready;
  assign amt_neg  = in_item.mole_amount[AMT_W-1];
  assign store_ok = (cnt_r < MAX_CNT);
  assign in_gas   = !in_item.mode;
  assign zero_hit = store_ok && (in_item.mole_amount == '0) && !zero_r;

  always_comb begin
    cnt_nxt  = (cnt_r <= MAX_CNT) ? cnt_r + CNT_W'(1) : cnt_r;
    sum_nxt  = amt_neg ? sum_r
                       : sum_r + {{(SUM_W-AMT_W){1'b0}}, in_item.mole_amount};
    neg_nxt  = neg_r | amt_neg;
    zero_nxt = zero_r | zero_hit;
    zidx_nxt = zero_hit ? cnt_r[IDX_W-1:0] : zidx_r;
    if (in_item.temperature == '0 || in_item.pressure == '0 ||
        (in_gas && ref_p_r == '0)) begin
      st_w = ST_BAD_STATE;
    end else if (cnt_nxt > MAX_CNT || CMP_W'(cnt_nxt) != CMP_W'(spc_cnt_r)) begin
      st_w = ST_MISMATCH;
    end else if (neg_nxt) begin
      st_w = ST_NEGATIVE;
    end else if (sum_nxt == '0) begin
      st_w = ST_ZERO_SUM;
    end else if (zero_nxt) begin
      st_w = ST_ZERO_ACT;
    end else begin
      st_w = ST_OK;
    end
  end

  // Shared multiplier: one 32x32 partial product per cycle.
  logic [31:0]  a_half, b_half;
  logic [63:0]  pp_w;
  logic [1:0]   pidx;
  logic [6:0]   pshift;
  assign a_half = mcnt_r[1] ? mul_a_r[63:32] : mul_a_r[31:0];
  assign b_half = mcnt_r[0] ? mul_b_r[63:32] : mul_b_r[31:0];
  assign pp_w   = a_half * b_half;
  assign pidx   = 2'(mcnt_r - 3'd1);
  assign pshift = (pidx == 2'd0) ? 7'd0 : (pidx == 2'd3) ? 7'd64 : 7'd32;

  // Squaring step of the logarithm and the per-species arithmetic.
  logic [63:0]             sq_w, m_new, term_w, term_c;
  logic [31:0]             frac_new;
  logic [LOG_W-1:0]        log_val;
  logic signed [BASE_W-1:0] lv_s, d_w;
  logic [BASE_W-1:0]       mag_w;
  logic signed [POT_W+1:0] mu_w, mu_sat;

  always_comb begin
    sq_w     = mul_shr(acc_r, 62);
    frac_new = {frac_r[30:0], sq_w[63]};
    m_new    = sq_w[63] ? (sq_w >> 1) : sq_w;
    log_val  = {k_r, frac_new};
    lv_s     = $signed({{(BASE_W-LOG_W){1'b0}}, log_val});
    d_w      = base_r + lv_s;
    mag_w    = d_w[BASE_W-1] ? BASE_W'(-d_w) : BASE_W'(d_w);
    term_w   = mul_shr(acc_r, LOG_FRACTION_BITS);
    term_c   = (term_w > TERM_MAX) ? TERM_MAX : term_w;
    mu_w     = neg_d_r ? $signed({{2{pot_rd_r[POT_W-1]}}, pot_rd_r})
                         - $signed({2'b00, term_c[POT_W-1:0]})
                       : $signed({{2{pot_rd_r[POT_W-1]}}, pot_rd_r})
                         + $signed({2'b00, term_c[POT_W-1:0]});
    if (mu_w > POT_HI) begin
      mu_sat = POT_HI;
    end else if (mu_w < POT_LO) begin
      mu_sat = POT_LO;
    end else begin
      mu_sat = mu_w;
    end
  end

  // Configuration registers.
  assign cfg_port.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spc_cnt_r <= SPECIES_COUNT_RST;
      ref_p_r   <= REF_PRESSURE_RST;
    end else if (cfg_port.valid) begin
      case (cfg_port.wr_index)
        CFG_SPECIES_COUNT: spc_cnt_r <= cfg_port.wr_data[SPECIES_W-1:0];
        CFG_REF_PRESSURE:  ref_p_r   <= cfg_port.wr_data[PRES_W-1:0];
        default: ;
      endcase
    end
  end

  // Species stores with registered read.
  always_ff @(posedge clk) begin
    if (in_acc && store_ok) begin
      amt_mem[cnt_r[IDX_W-1:0]] <= in_item.mole_amount;
      pot_mem[cnt_r[IDX_W-1:0]] <= in_item.standard_potential;
    end
    if (state_r == S_READ) begin
      amt_rd_r <= amt_mem[idx_r];
      pot_rd_r <= pot_mem[idx_r];
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      sum_r       <= '0;
      neg_r       <= 1'b0;
      zero_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_item.last_species) begin
              cnt_r  <= '0;
              sum_r  <= '0;
              neg_r  <= 1'b0;
              zero_r <= 1'b0;
              gas_r  <= in_gas;
              temp_r <= in_item.temperature;
              pres_r <= in_item.pressure;
              n_r    <= cnt_nxt;
              if (st_w != ST_OK) begin
                out_valid_r <= 1'b1;
                out_pot_r   <= '0;
                out_idx_r   <= (st_w == ST_ZERO_ACT) ? IDX_OUT_W'(zidx_nxt) : '0;
                out_st_r    <= st_w;
                out_last_r  <= 1'b1;
                state_r     <= S_OUT;
              end else begin
                m_r     <= 64'(sum_nxt);
                k_r     <= K_TOP;
                job_r   <= J_SUM;
                state_r <= S_NORM;
              end
            end else begin
              cnt_r  <= cnt_nxt;
              sum_r  <= sum_nxt;
              neg_r  <= neg_nxt;
              zero_r <= zero_nxt;
              zidx_r <= zidx_nxt;
            end
          end
        end
        // Normalize so the leading one sits at bit 62.
        S_NORM: begin
          if (m_r[62]) begin
            frac_r  <= '0;
            it_r    <= '0;
            mul_a_r <= m_r;
            mul_b_r <= m_r;
            mcnt_r  <= '0;
            acc_r   <= '0;
            mpost_r <= S_SQ_POST;
            state_r <= S_MUL;
          end else begin
            m_r <= m_r << 1;
            k_r <= k_r - 6'd1;
          end
        end
        S_MUL: begin
          if (mcnt_r < 3'd4) begin
            pp_r <= pp_w;
          end
          if (mcnt_r != 3'd0) begin
            acc_r <= acc_r + ({64'd0, pp_r} << pshift);
          end
          if (mcnt_r == 3'd4) begin
            state_r <= mpost_r;
          end else begin
            mcnt_r <= mcnt_r + 3'd1;
          end
        end
        // One fraction bit per squaring.
        S_SQ_POST: begin
          frac_r <= frac_new;
          mcnt_r <= '0;
          acc_r  <= '0;
          if (it_r != 5'd31) begin
            it_r    <= it_r + 5'd1;
            mul_a_r <= m_new;
            mul_b_r <= m_new;
            mpost_r <= S_SQ_POST;
            state_r <= S_MUL;
          end else begin
            case (job_r)
              J_SUM: begin
                base_r <= -lv_s;
                if (gas_r) begin
                  m_r     <= 64'(pres_r);
                  k_r     <= K_TOP;
                  job_r   <= J_PRES;
                  state_r <= S_NORM;
                end else begin
                  mul_a_r <= R_Q24;
                  mul_b_r <= 64'(temp_r);
                  mpost_r <= S_RT_POST;
                  state_r <= S_MUL;
                end
              end
              J_PRES: begin
                base_r  <= base_r + lv_s;
                m_r     <= 64'(ref_p_r);
                k_r     <= K_TOP;
                job_r   <= J_REF;
                state_r <= S_NORM;
              end
              J_REF: begin
                base_r  <= base_r - lv_s;
                mul_a_r <= R_Q24;
                mul_b_r <= 64'(temp_r);
                mpost_r <= S_RT_POST;
                state_r <= S_MUL;
              end
              default: begin
                neg_d_r <= d_w[BASE_W-1];
                mul_a_r <= 64'(mag_w);
                mul_b_r <= LN2_Q28;
                mpost_r <= S_LN_POST;
                state_r <= S_MUL;
              end
            endcase
          end
        end
        S_RT_POST: begin
          rt_r    <= mul_shr(acc_r, 24);
          idx_r   <= '0;
          state_r <= S_READ;
        end
        S_READ: begin
          state_r <= S_AMT;
        end
        S_AMT: begin
          m_r     <= 64'(amt_rd_r);
          k_r     <= K_TOP;
          job_r   <= J_AMT;
          state_r <= S_NORM;
        end
        S_LN_POST: begin
          mul_a_r <= mul_shr(acc_r, LN_SH);
          mul_b_r <= rt_r;
          mcnt_r  <= '0;
          acc_r   <= '0;
          mpost_r <= S_TERM_POST;
          state_r <= S_MUL;
        end
        S_TERM_POST: begin
          out_valid_r <= 1'b1;
          out_pot_r   <= POT_W'(mu_sat);
          out_idx_r   <= IDX_OUT_W'(idx_r);
          out_st_r    <= ST_OK;
          out_last_r  <= (CNT_W'(idx_r) + CNT_W'(1)) == n_r;
          state_r     <= S_OUT;
        end
        // Hold the result until the receiver takes it.
        S_OUT: begin
          if (out_item.ready) begin
            out_valid_r <= 1'b0;
            if (out_last_r) begin
              state_r <= S_IDLE;
            end else begin
              idx_r   <= idx_r + IDX_W'(1);
              state_r <= S_READ;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_item.valid         = out_valid_r;
  assign out_item.potential     = out_pot_r;
  assign out_item.species_index = out_idx_r;
  assign out_item.status        = out_st_r;
  assign out_item.last_result   = out_last_r;

endmodule
